>>> sv/rmh_pkg.sv
package rmh_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEDIAN_W-1:0] median_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic signed [MEDIAN_W-1:0] median_x2;
        logic                       full_res;
    } out_item_t;

endpackage

>>> sv/rmh_if.sv
interface rmh_in_if;
    logic              valid;
    logic              ready;
    rmh_pkg::in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rmh_out_if;
    logic               valid;
    logic               ready;
    rmh_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> sv/running_median_two_heaps_unit.sv
// Running median over a stream of signed 32-bit samples, kept in two heaps.
// Channels:
//   in_ch  : one transaction carries one sample.
//   out_ch : one transaction per sample: median_x2 (median times two) and
//            full_res (sample dropped because its heap was full).
// One shared comparator and one heap memory port (registered read) per side.
// Sequence, from the accepting edge to out_ch.valid:
//   dropped sample: straight to the output register.
//   insert only: the sample is sifted up its heap.
//   with rebalance: after the insert, a pop with the last entry sifted down,
//   then an insert of the popped top into the other heap.
// Throughput: one sample at a time. The next sample is accepted no earlier
//   than the cycle after the result is taken.
// in_ch.ready is high only while the sequencer is idle and the output
//   register is free, so a stalled receiver holds off new samples.
// Reset: both heaps empty; heap memories need no clearing, since only
//   entries below a heap's count are read.
module running_median_two_heaps_unit #(
    parameter int HEAP_DEPTH = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    rmh_in_if.sink           in_ch,
    rmh_out_if.source        out_ch
);

    localparam int AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_PUSH_RD, S_PUSH_CMP, S_CHECK, S_POP_LAST, S_POP_LATCH,
        S_POP_RDL, S_POP_RDR, S_POP_PICK, S_POP_CMP, S_POP_END, S_OUT
    } state_t;

    typedef enum logic {PH_NONE, PH_REBAL} phase_t;

    rmh_pkg::sample_t lo_mem [HEAP_DEPTH];
    rmh_pkg::sample_t hi_mem [HEAP_DEPTH];

    state_t  state_reg;
    phase_t  phase_reg;
    logic [CW-1:0] lo_cnt_reg, hi_cnt_reg;
    rmh_pkg::sample_t lo_top_reg, hi_top_reg;
    logic    side_reg;
    rmh_pkg::sample_t val_reg;
    rmh_pkg::sample_t moved_reg;
    logic [AW-1:0] idx_reg;
    logic [CW-1:0] n_reg;
    rmh_pkg::sample_t cl_reg;
    logic [AW-1:0] best_idx_reg;
    logic    full_reg;
    logic    out_valid_reg;
    rmh_pkg::out_item_t out_reg;

    // memory port: one read and one write per cycle, on the side selected
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    rmh_pkg::sample_t wr_data;

    rmh_pkg::sample_t rd_data_lo, rd_data_hi, rd_data;
    assign rd_data = side_reg ? rd_data_hi : rd_data_lo;

    always_ff @(posedge clk)
    begin
        rd_data_lo <= lo_mem[rd_addr];
        rd_data_hi <= hi_mem[rd_addr];
        if (we && !side_reg)
        begin
            lo_mem[wr_addr] <= wr_data;
        end
        if (we && side_reg)
        begin
            hi_mem[wr_addr] <= wr_data;
        end
    end

    logic [AW-1:0] parent_idx;
    logic [AW:0]   lchild;
    logic [AW+1:0] n_ext;
    logic          c_valid;
    logic          r_valid;
    assign parent_idx = (idx_reg - AW'(1)) >> 1;
    assign lchild     = {idx_reg, 1'b1};
    assign n_ext      = (AW+2)'(n_reg);
    assign c_valid    = {1'b0, lchild} < n_ext;
    assign r_valid    = ({1'b0, lchild} + (AW+2)'(1)) < n_ext;

    logic [CW:0] lo_w, hi_w;
    assign lo_w = {1'b0, lo_cnt_reg};
    assign hi_w = {1'b0, hi_cnt_reg};

    // shared comparator: true if cmp_a ranks above cmp_b
    logic          cmp_max;
    rmh_pkg::sample_t cmp_a, cmp_b;
    logic          cmp_out;

    always_comb
    begin
        cmp_max = !side_reg;
        cmp_a   = val_reg;
        cmp_b   = rd_data;
        case (state_reg)
            S_IDLE:
            begin
                cmp_max = 1'b1;
                cmp_a   = in_ch.data.sample;
                cmp_b   = lo_top_reg;
            end
            S_POP_PICK:
            begin
                cmp_a = rd_data;
                cmp_b = cl_reg;
            end
            S_POP_CMP:
            begin
                cmp_a = cl_reg;
                cmp_b = val_reg;
            end
            default: ;
        endcase
    end

    assign cmp_out = cmp_max ? (cmp_a > cmp_b) : (cmp_a < cmp_b);

    logic to_low;
    assign to_low = (lo_cnt_reg == '0) || !cmp_out;

    always_comb
    begin
        rd_addr = '0;
        we      = 1'b0;
        wr_addr = idx_reg;
        wr_data = val_reg;
        case (state_reg)
            S_PUSH_RD:
            begin
                if (idx_reg == '0)
                begin
                    we = 1'b1;
                end
                else
                begin
                    rd_addr = parent_idx;
                end
            end
            S_PUSH_CMP:
            begin
                we = 1'b1;
                if (cmp_out)
                begin
                    wr_data = rd_data;
                end
            end
            S_POP_LAST: rd_addr = AW'(n_reg);
            S_POP_RDL:
            begin
                if (c_valid)
                begin
                    rd_addr = AW'(lchild);
                end
                else
                begin
                    we = 1'b1;
                end
            end
            S_POP_RDR:
            begin
                if (r_valid)
                begin
                    rd_addr = AW'(lchild + (AW+1)'(1));
                end
            end
            S_POP_CMP:
            begin
                we = 1'b1;
                if (cmp_out)
                begin
                    wr_data = cl_reg;
                end
            end
            default: ;
        endcase
    end

    rmh_pkg::median_t median_calc;

    always_comb
    begin
        if (lo_cnt_reg == '0 && hi_cnt_reg == '0)
        begin
            median_calc = '0;
        end
        else if (lo_cnt_reg == hi_cnt_reg)
        begin
            median_calc = {lo_top_reg[31], lo_top_reg} + {hi_top_reg[31], hi_top_reg};
        end
        else if (lo_cnt_reg > hi_cnt_reg)
        begin
            median_calc = {lo_top_reg, 1'b0};
        end
        else
        begin
            median_calc = {hi_top_reg, 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_NONE;
            lo_cnt_reg    <= '0;
            hi_cnt_reg    <= '0;
            lo_top_reg    <= '0;
            hi_top_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            full_reg      <= 1'b0;
            side_reg      <= 1'b0;
            val_reg       <= '0;
            moved_reg     <= '0;
            idx_reg       <= '0;
            n_reg         <= '0;
            cl_reg        <= '0;
            best_idx_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // heap tops mirror entry 0 of each memory
            if (we && wr_addr == '0)
            begin
                if (side_reg)
                begin
                    hi_top_reg <= wr_data;
                end
                else
                begin
                    lo_top_reg <= wr_data;
                end
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid && in_ch.ready)
                    begin
                        side_reg  <= !to_low;
                        val_reg   <= in_ch.data.sample;
                        phase_reg <= PH_NONE;
                        if (to_low ? (lo_cnt_reg >= DEPTH_C) : (hi_cnt_reg >= DEPTH_C))
                        begin
                            full_reg  <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            full_reg <= 1'b0;
                            if (to_low)
                            begin
                                idx_reg    <= AW'(lo_cnt_reg);
                                lo_cnt_reg <= lo_cnt_reg + CW'(1);
                            end
                            else
                            begin
                                idx_reg    <= AW'(hi_cnt_reg);
                                hi_cnt_reg <= hi_cnt_reg + CW'(1);
                            end
                            state_reg <= S_PUSH_RD;
                        end
                    end
                end
                S_PUSH_RD:
                begin
                    if (idx_reg == '0)
                    begin
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        state_reg <= S_PUSH_CMP;
                    end
                end
                S_PUSH_CMP:
                begin
                    if (cmp_out)
                    begin
                        idx_reg   <= parent_idx;
                        state_reg <= S_PUSH_RD;
                    end
                    else
                    begin
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    idx_reg <= '0;
                    if (phase_reg == PH_NONE && lo_w > hi_w + (CW+1)'(1))
                    begin
                        side_reg   <= 1'b0;
                        moved_reg  <= lo_top_reg;
                        n_reg      <= lo_cnt_reg - CW'(1);
                        lo_cnt_reg <= lo_cnt_reg - CW'(1);
                        state_reg  <= S_POP_LAST;
                    end
                    else if (phase_reg == PH_NONE && hi_w > lo_w + (CW+1)'(1))
                    begin
                        side_reg   <= 1'b1;
                        moved_reg  <= hi_top_reg;
                        n_reg      <= hi_cnt_reg - CW'(1);
                        hi_cnt_reg <= hi_cnt_reg - CW'(1);
                        state_reg  <= S_POP_LAST;
                    end
                    else
                    begin
                        state_reg <= S_OUT;
                    end
                end
                S_POP_LAST:
                begin
                    state_reg <= S_POP_LATCH;
                end
                S_POP_LATCH:
                begin
                    val_reg   <= rd_data;
                    state_reg <= S_POP_RDL;
                end
                S_POP_RDL:
                begin
                    if (c_valid)
                    begin
                        state_reg <= S_POP_RDR;
                    end
                    else
                    begin
                        state_reg <= S_POP_END;
                    end
                end
                S_POP_RDR:
                begin
                    cl_reg       <= rd_data;
                    best_idx_reg <= AW'(lchild);
                    state_reg    <= r_valid ? S_POP_PICK : S_POP_CMP;
                end
                S_POP_PICK:
                begin
                    if (cmp_out)
                    begin
                        cl_reg       <= rd_data;
                        best_idx_reg <= AW'(lchild + (AW+1)'(1));
                    end
                    state_reg <= S_POP_CMP;
                end
                S_POP_CMP:
                begin
                    if (cmp_out)
                    begin
                        idx_reg   <= best_idx_reg;
                        state_reg <= S_POP_RDL;
                    end
                    else
                    begin
                        state_reg <= S_POP_END;
                    end
                end
                S_POP_END:
                begin
                    side_reg  <= !side_reg;
                    val_reg   <= moved_reg;
                    phase_reg <= PH_REBAL;
                    if (side_reg)
                    begin
                        idx_reg    <= AW'(lo_cnt_reg);
                        lo_cnt_reg <= lo_cnt_reg + CW'(1);
                    end
                    else
                    begin
                        idx_reg    <= AW'(hi_cnt_reg);
                        hi_cnt_reg <= hi_cnt_reg + CW'(1);
                    end
                    state_reg <= S_PUSH_RD;
                end
                S_OUT:
                begin
                    out_reg.median_x2 <= median_calc;
                    out_reg.full_res  <= full_reg;
                    out_valid_reg     <= 1'b1;
                    state_reg         <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ch.ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data));

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_ch.valid && state_reg == S_IDLE);

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        lo_cnt_reg <= DEPTH_C && hi_cnt_reg <= DEPTH_C);

    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> lo_w <= hi_w + (CW+1)'(1) && hi_w <= lo_w + (CW+1)'(1));

endmodule

>>> verif/running_median_two_heaps_unit_checker.sv
`timescale 1ns / 1ps

module running_median_two_heaps_unit_checker #(
    parameter int HEAP_DEPTH = 512
) (
    input  logic  clk,
    input  logic  rst_n,
    rmh_in_if     in_ch,
    rmh_out_if    out_ch,
    output int    fail_count,
    output int    pending_count,
    output int    median_count,
    output int    drop_count
);

    rmh_pkg::sample_t   lo_heap [HEAP_DEPTH];
    rmh_pkg::sample_t   hi_heap [HEAP_DEPTH];
    int                 lo_n;
    int                 hi_n;
    rmh_pkg::out_item_t median_q [$];

    function automatic bit ranks_above(rmh_pkg::sample_t a, rmh_pkg::sample_t b, bit is_max);
        return is_max ? (a > b) : (a < b);
    endfunction

    task automatic heap_insert(ref rmh_pkg::sample_t h [HEAP_DEPTH], ref int n,
                               input rmh_pkg::sample_t v, input bit is_max);
        int i;
        int p;
        i = n;
        n = n + 1;
        while (i > 0)
        begin
            p = (i - 1) / 2;
            if (!ranks_above(v, h[p], is_max))
                break;
            h[i] = h[p];
            i = p;
        end
        h[i] = v;
    endtask

    task automatic heap_remove_top(ref rmh_pkg::sample_t h [HEAP_DEPTH], ref int n,
                                   input bit is_max, output rmh_pkg::sample_t top);
        int i;
        int c;
        rmh_pkg::sample_t last;
        i = 0;
        top = h[0];
        n = n - 1;
        last = h[n];
        forever
        begin
            c = 2 * i + 1;
            if (c >= n)
                break;
            if (c + 1 < n && ranks_above(h[c + 1], h[c], is_max))
                c++;
            if (!ranks_above(h[c], last, is_max))
                break;
            h[i] = h[c];
            i = c;
        end
        if (n > 0)
            h[i] = last;
    endtask

    task automatic add_sample(input rmh_pkg::sample_t v);
        bit                 to_lo;
        bit                 dropped;
        rmh_pkg::sample_t   t;
        rmh_pkg::out_item_t r;
        to_lo = (lo_n == 0) || !(v > lo_heap[0]);
        dropped = to_lo ? (lo_n >= HEAP_DEPTH) : (hi_n >= HEAP_DEPTH);
        if (!dropped)
        begin
            if (to_lo)
                heap_insert(lo_heap, lo_n, v, 1'b1);
            else
                heap_insert(hi_heap, hi_n, v, 1'b0);
            if (lo_n > hi_n + 1)
            begin
                heap_remove_top(lo_heap, lo_n, 1'b1, t);
                heap_insert(hi_heap, hi_n, t, 1'b0);
            end
            else if (hi_n > lo_n + 1)
            begin
                heap_remove_top(hi_heap, hi_n, 1'b0, t);
                heap_insert(lo_heap, lo_n, t, 1'b1);
            end
        end
        if (lo_n == 0 && hi_n == 0)
            r.median_x2 = '0;
        else if (lo_n == hi_n)
            r.median_x2 = rmh_pkg::median_t'(lo_heap[0]) + rmh_pkg::median_t'(hi_heap[0]);
        else if (lo_n > hi_n)
            r.median_x2 = rmh_pkg::median_t'(lo_heap[0]) <<< 1;
        else
            r.median_x2 = rmh_pkg::median_t'(hi_heap[0]) <<< 1;
        r.full_res = dropped;
        median_q.insert(median_q.size(), r);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rmh_pkg::out_item_t want;
        if (!rst_n)
        begin
            lo_n = 0;
            hi_n = 0;
            median_q.delete();
            pending_count = 0;
            fail_count <= 0;
            median_count <= 0;
            drop_count <= 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                median_count <= median_count + 1;
                if (median_q.size() == 0)
                begin
                    fail_count <= fail_count + 1;
                    if (fail_count < 10)
                        $display("unexpected transaction: median_x2=%0d full_res=%0b",
                                 out_ch.data.median_x2, out_ch.data.full_res);
                end
                else
                begin
                    want = median_q.pop_front();
                    if (want.full_res)
                        drop_count <= drop_count + 1;
                    if (want !== out_ch.data)
                    begin
                        fail_count <= fail_count + 1;
                        if (fail_count < 10)
                            $display("mismatch: median_x2 exp %0d got %0d, full_res exp %0b got %0b",
                                     want.median_x2, out_ch.data.median_x2,
                                     want.full_res, out_ch.data.full_res);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
                add_sample(in_ch.data.sample);
            pending_count = median_q.size();
        end
    end
endmodule

>>> verif/running_median_two_heaps_unit_test.sv
`timescale 1ns / 1ps

module running_median_two_heaps_unit_test;

    localparam int HEAP_DEPTH = 512;

    logic clk;
    logic rst_n;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   fail_count;
    int   pending_count;
    int   median_count;
    int   drop_count;
    int   sent;

    rmh_in_if  in_ch ();
    rmh_out_if out_ch ();

    running_median_two_heaps_unit #(.HEAP_DEPTH(HEAP_DEPTH)) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    running_median_two_heaps_unit_checker #(.HEAP_DEPTH(HEAP_DEPTH)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .median_count  (median_count),
        .drop_count    (drop_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
        out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);

    task automatic send_sample(input rmh_pkg::sample_t v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data.sample <= v;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sent++;
    endtask

    function automatic rmh_pkg::sample_t rand_sample();
        case ($urandom_range(5))
            0: return rmh_pkg::sample_t'($urandom);
            1: return rmh_pkg::sample_t'($urandom_range(40)) - 20;
            2: return 32'sh7fffffff - rmh_pkg::sample_t'($urandom_range(3));
            3: return 32'sh80000000 + rmh_pkg::sample_t'($urandom_range(3));
            default: return rmh_pkg::sample_t'($urandom_range(2000)) - 1000;
        endcase
    endfunction

    initial
    begin
        rmh_pkg::sample_t ext [6];
        ext = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 0, -1};
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        send_idle_pct = 16;
        recv_idle_pct = 46;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (ext[i])
            send_sample(ext[i]);
        for (int i = 0; i < 12; i++)
            send_sample(rmh_pkg::sample_t'(i % 3) - 1);
        for (int i = 0; i < 632; i++)
        begin
            if (i == 200)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 16;
            end
            else if (i == 400)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            send_sample(rand_sample());
        end
        in_ch.valid <= 1'b0;
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        $display("%0d samples sent, %0d medians checked, %0d dropped on full heap",
                 sent, median_count, drop_count);
        if (fail_count == 0)
            $display("[running_median_two_heaps_unit] OK");
        else
            $display("[running_median_two_heaps_unit] ERROR");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("[running_median_two_heaps_unit] ERROR");
        $finish;
    end
endmodule

>>> running_median_two_heaps_unit.f
sv/rmh_pkg.sv
sv/rmh_if.sv
sv/running_median_two_heaps_unit.sv
verif/running_median_two_heaps_unit_checker.sv
verif/running_median_two_heaps_unit_test.sv
